### design/kinematic_integrator_speed_limit_macros.svh
// ---------------------------------------------------------------------------
// kinematic integrator assertion macros
// shared concurrent assertion forms, clocked on clk and held off during rst
// ---------------------------------------------------------------------------
`ifndef KINEMATIC_INTEGRATOR_SPEED_LIMIT_MACROS_SVH
`define KINEMATIC_INTEGRATOR_SPEED_LIMIT_MACROS_SVH

// same-cycle implication
`define KISL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication
`define KISL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

### design/kisl_pkg.sv
// ---------------------------------------------------------------------------
// kisl_pkg
// types, constants and helper functions of the kinematic integrator
// ---------------------------------------------------------------------------
package kisl_pkg;

  // field format
  localparam int FIELD_W   = 24;
  localparam int SPEED_W   = 23;
  localparam int FRAC_BITS = 12;
  localparam logic signed [FIELD_W-1:0] FIELD_MAX = 24'sh7FFFFF;
  localparam logic signed [FIELD_W-1:0] FIELD_MIN = 24'sh800000;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RESET = 23'd16384;

  // world size and wrap limits, saturated to the field range
  localparam int WORLD_WIDTH  = 1024;
  localparam int WORLD_HEIGHT = 1024;
  localparam int FIELD_MAX_INT = 8388607;
  localparam int WRAP_X_INT = (WORLD_WIDTH * (2 ** FRAC_BITS) > FIELD_MAX_INT) ?
                              FIELD_MAX_INT : WORLD_WIDTH * (2 ** FRAC_BITS);
  localparam int WRAP_Y_INT = (WORLD_HEIGHT * (2 ** FRAC_BITS) > FIELD_MAX_INT) ?
                              FIELD_MAX_INT : WORLD_HEIGHT * (2 ** FRAC_BITS);
  localparam logic signed [FIELD_W-1:0] WRAP_X = FIELD_W'(WRAP_X_INT);
  localparam logic signed [FIELD_W-1:0] WRAP_Y = FIELD_W'(WRAP_Y_INT);

  // iterative units: root digits and quotient bits, two per cycle
  localparam int PROD_W          = 2 * FIELD_W;
  localparam int STEPS_PER_CYCLE = 2;
  localparam int ITER_CYCLES     = FIELD_W / STEPS_PER_CYCLE;
  localparam int ITER_W          = $clog2(ITER_CYCLES);

  // command codes
  localparam logic [1:0] CMD_APPLY  = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_LOAD   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]                command;
    logic signed [FIELD_W-1:0] vec_x;
    logic signed [FIELD_W-1:0] vec_y;
    logic signed [FIELD_W-1:0] load_vel_x;
    logic signed [FIELD_W-1:0] load_vel_y;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] vel_x;
    logic signed [FIELD_W-1:0] vel_y;
    logic                      speed_limited;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_APPLY, ST_LOAD, ST_VEL, ST_ABS, ST_SQX, ST_SQY, ST_SQL, ST_CMP,
    ST_SQRT, ST_MULX, ST_MULY, ST_DIVI, ST_DIV, ST_SCALE, ST_POS, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MUL_XX, MUL_YY, MUL_LL, MUL_XL, MUL_YL
  } mul_sel_t;

  typedef enum logic [1:0] {
    M2_HOLD, M2_LOAD, M2_ADD
  } m2_op_t;

  // controller to datapath
  typedef struct packed {
    logic     latch;
    logic     do_apply;
    logic     do_load;
    logic     do_vel;
    logic     do_abs;
    logic     mul_en;
    mul_sel_t mul_sel;
    m2_op_t   m2_op;
    logic     keep_x;
    logic     sqrt_init;
    logic     sqrt_step;
    logic     div_init;
    logic     div_step;
    logic     do_scale;
    logic     do_pos;
    logic     out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic       over;
  } dp_sts_t;

  // saturating signed add
  function automatic logic signed [FIELD_W-1:0] sat_add(
    input logic signed [FIELD_W-1:0] a,
    input logic signed [FIELD_W-1:0] b
  );
    logic signed [FIELD_W:0] s;
    s = (FIELD_W+1)'(a) + (FIELD_W+1)'(b);
    if (s[FIELD_W] != s[FIELD_W-1]) begin
      return s[FIELD_W] ? FIELD_MIN : FIELD_MAX;
    end
    return s[FIELD_W-1:0];
  endfunction

  // wrap one position axis into [0, lim]
  function automatic logic signed [FIELD_W-1:0] wrap_axis(
    input logic signed [FIELD_W-1:0] p,
    input logic signed [FIELD_W-1:0] lim
  );
    if (p > lim) begin
      return '0;
    end
    if (p < 0) begin
      return lim;
    end
    return p;
  endfunction

endpackage

### design/kisl_ctrl.sv
// ---------------------------------------------------------------------------
// kisl_ctrl
// sequencer of the kinematic integrator: walks each command through the
// datapath and owns the input ready and the output valid
// ---------------------------------------------------------------------------
module kisl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output kisl_pkg::dp_cmd_t cmd,
  input  kisl_pkg::dp_sts_t sts
);

  kisl_pkg::state_t state, state_next;
  logic [kisl_pkg::ITER_W-1:0] iter_cnt;
  logic iter_last;
  logic out_free;

  assign iter_last = (iter_cnt == kisl_pkg::ITER_W'(kisl_pkg::ITER_CYCLES - 1));
  assign out_free  = !out_valid || out_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kisl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // iteration counter for root and divide
  always_ff @(posedge clk) begin
    if (rst) begin
      iter_cnt <= '0;
    end else if (state == kisl_pkg::ST_SQRT || state == kisl_pkg::ST_DIV) begin
      iter_cnt <= iter_cnt + 1'b1;
    end else begin
      iter_cnt <= '0;
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      kisl_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (sts.command)
            kisl_pkg::CMD_APPLY: state_next = kisl_pkg::ST_APPLY;
            kisl_pkg::CMD_TICK:  state_next = kisl_pkg::ST_VEL;
            kisl_pkg::CMD_LOAD:  state_next = kisl_pkg::ST_LOAD;
            default:             state_next = kisl_pkg::ST_IDLE;
          endcase
        end
      end
      kisl_pkg::ST_APPLY: state_next = kisl_pkg::ST_DONE;
      kisl_pkg::ST_LOAD:  state_next = kisl_pkg::ST_DONE;
      kisl_pkg::ST_VEL:   state_next = kisl_pkg::ST_ABS;
      kisl_pkg::ST_ABS:   state_next = kisl_pkg::ST_SQX;
      kisl_pkg::ST_SQX:   state_next = kisl_pkg::ST_SQY;
      kisl_pkg::ST_SQY:   state_next = kisl_pkg::ST_SQL;
      kisl_pkg::ST_SQL:   state_next = kisl_pkg::ST_CMP;
      kisl_pkg::ST_CMP: begin
        state_next = sts.over ? kisl_pkg::ST_SQRT : kisl_pkg::ST_POS;
      end
      kisl_pkg::ST_SQRT: begin
        if (iter_last) begin
          state_next = kisl_pkg::ST_MULX;
        end
      end
      kisl_pkg::ST_MULX:  state_next = kisl_pkg::ST_MULY;
      kisl_pkg::ST_MULY:  state_next = kisl_pkg::ST_DIVI;
      kisl_pkg::ST_DIVI:  state_next = kisl_pkg::ST_DIV;
      kisl_pkg::ST_DIV: begin
        if (iter_last) begin
          state_next = kisl_pkg::ST_SCALE;
        end
      end
      kisl_pkg::ST_SCALE: state_next = kisl_pkg::ST_POS;
      kisl_pkg::ST_POS:   state_next = kisl_pkg::ST_DONE;
      kisl_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = kisl_pkg::ST_IDLE;
        end
      end
      default: state_next = kisl_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = kisl_pkg::MUL_XX;
    cmd.m2_op    = kisl_pkg::M2_HOLD;
    in_ready     = 1'b0;
    case (state)
      kisl_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      kisl_pkg::ST_APPLY: cmd.do_apply = 1'b1;
      kisl_pkg::ST_LOAD:  cmd.do_load  = 1'b1;
      kisl_pkg::ST_VEL:   cmd.do_vel   = 1'b1;
      kisl_pkg::ST_ABS:   cmd.do_abs   = 1'b1;
      kisl_pkg::ST_SQX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = kisl_pkg::MUL_XX;
      end
      kisl_pkg::ST_SQY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = kisl_pkg::MUL_YY;
        cmd.m2_op   = kisl_pkg::M2_LOAD;
      end
      kisl_pkg::ST_SQL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = kisl_pkg::MUL_LL;
        cmd.m2_op   = kisl_pkg::M2_ADD;
      end
      kisl_pkg::ST_CMP:  cmd.sqrt_init = 1'b1;
      kisl_pkg::ST_SQRT: cmd.sqrt_step = 1'b1;
      kisl_pkg::ST_MULX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = kisl_pkg::MUL_XL;
      end
      kisl_pkg::ST_MULY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = kisl_pkg::MUL_YL;
        cmd.keep_x  = 1'b1;
      end
      kisl_pkg::ST_DIVI:  cmd.div_init = 1'b1;
      kisl_pkg::ST_DIV:   cmd.div_step = 1'b1;
      kisl_pkg::ST_SCALE: cmd.do_scale = 1'b1;
      kisl_pkg::ST_POS:   cmd.do_pos   = 1'b1;
      kisl_pkg::ST_DONE:  cmd.out_load = out_free;
      default: begin
      end
    endcase
  end

endmodule

### design/kisl_dp.sv
// ---------------------------------------------------------------------------
// kisl_dp
// datapath of the kinematic integrator: agent state, shared multiplier,
// two-digit-per-cycle square root, two dividers and the output register
// ---------------------------------------------------------------------------
module kisl_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  kisl_pkg::in_item_t                  in_data,
  output kisl_pkg::out_item_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [kisl_pkg::SPEED_W-1:0]        cfg_wr_data,
  input  kisl_pkg::dp_cmd_t                   cmd,
  output kisl_pkg::dp_sts_t                   sts
);

  localparam int FW = kisl_pkg::FIELD_W;
  localparam int PW = kisl_pkg::PROD_W;

  // agent state and config
  logic signed [FW-1:0] position_x, position_y;
  logic signed [FW-1:0] velocity_x, velocity_y;
  logic signed [FW-1:0] force_sum_x, force_sum_y;
  logic [kisl_pkg::SPEED_W-1:0] max_speed;
  logic limited;

  // captured item
  kisl_pkg::in_item_t item;

  // multiply and magnitude
  logic [FW-1:0] abs_x, abs_y;
  logic [FW-1:0] mul_a, mul_b;
  logic [PW-1:0] prod, prod_x, m2;

  // square root
  logic [PW-1:0] sq_n, sq_n_next;
  logic [FW+1:0] sq_rem, sq_rem_next;
  logic [FW-1:0] sq_root, sq_root_next;

  // dividers
  logic [FW-1:0] dx_r, dx_r_next, dx_d, dx_d_next, qx, qx_next;
  logic [FW-1:0] dy_r, dy_r_next, dy_d, dy_d_next, qy, qy_next;

  assign sts.command = in_data.command;
  assign sts.over    = (m2 > prod);

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= kisl_pkg::MAX_SPEED_RESET;
    end else if (cfg_wr_en) begin
      max_speed <= cfg_wr_data;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item <= in_data;
    end
  end

  // agent state update
  always_ff @(posedge clk) begin
    if (rst) begin
      position_x  <= '0;
      position_y  <= '0;
      velocity_x  <= '0;
      velocity_y  <= '0;
      force_sum_x <= '0;
      force_sum_y <= '0;
      limited     <= 1'b0;
    end else begin
      if (cmd.latch) begin
        limited <= 1'b0;
      end
      if (cmd.do_apply) begin
        force_sum_x <= kisl_pkg::sat_add(force_sum_x, item.vec_x);
        force_sum_y <= kisl_pkg::sat_add(force_sum_y, item.vec_y);
      end
      if (cmd.do_load) begin
        position_x  <= item.vec_x;
        position_y  <= item.vec_y;
        velocity_x  <= item.load_vel_x;
        velocity_y  <= item.load_vel_y;
        force_sum_x <= '0;
        force_sum_y <= '0;
      end
      if (cmd.do_vel) begin
        velocity_x <= kisl_pkg::sat_add(velocity_x, force_sum_x);
        velocity_y <= kisl_pkg::sat_add(velocity_y, force_sum_y);
      end
      if (cmd.do_scale) begin
        velocity_x <= velocity_x[FW-1] ? (FW'(0) - $signed(qx)) : $signed(qx);
        velocity_y <= velocity_y[FW-1] ? (FW'(0) - $signed(qy)) : $signed(qy);
        limited    <= 1'b1;
      end
      if (cmd.do_pos) begin
        position_x  <= kisl_pkg::wrap_axis(kisl_pkg::sat_add(position_x, velocity_x),
                                           kisl_pkg::WRAP_X);
        position_y  <= kisl_pkg::wrap_axis(kisl_pkg::sat_add(position_y, velocity_y),
                                           kisl_pkg::WRAP_Y);
        force_sum_x <= '0;
        force_sum_y <= '0;
      end
    end
  end

  // velocity magnitudes per axis
  always_ff @(posedge clk) begin
    if (cmd.do_abs) begin
      abs_x <= velocity_x[FW-1] ? (FW'(0) - velocity_x) : velocity_x;
      abs_y <= velocity_y[FW-1] ? (FW'(0) - velocity_y) : velocity_y;
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      kisl_pkg::MUL_XX: begin
        mul_a = abs_x;
        mul_b = abs_x;
      end
      kisl_pkg::MUL_YY: begin
        mul_a = abs_y;
        mul_b = abs_y;
      end
      kisl_pkg::MUL_LL: begin
        mul_a = FW'(max_speed);
        mul_b = FW'(max_speed);
      end
      kisl_pkg::MUL_XL: begin
        mul_a = abs_x;
        mul_b = FW'(max_speed);
      end
      kisl_pkg::MUL_YL: begin
        mul_a = abs_y;
        mul_b = FW'(max_speed);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // product, x product hold and sum of squares
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.keep_x) begin
      prod_x <= prod;
    end
    case (cmd.m2_op)
      kisl_pkg::M2_LOAD: m2 <= prod;
      kisl_pkg::M2_ADD:  m2 <= m2 + prod;
      default: begin
      end
    endcase
  end

  // square root, two result digits per cycle
  always_comb begin
    logic [FW+3:0] rem_sh;
    logic [FW+3:0] trial;
    sq_n_next    = sq_n;
    sq_rem_next  = sq_rem;
    sq_root_next = sq_root;
    for (int i = 0; i < kisl_pkg::STEPS_PER_CYCLE; i++) begin
      rem_sh    = {sq_rem_next, sq_n_next[PW-1 -: 2]};
      trial     = {2'b00, sq_root_next, 2'b01};
      sq_n_next = {sq_n_next[PW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_sh       = rem_sh - trial;
        sq_root_next = {sq_root_next[FW-2:0], 1'b1};
      end else begin
        sq_root_next = {sq_root_next[FW-2:0], 1'b0};
      end
      sq_rem_next = rem_sh[FW+1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sq_n    <= m2;
      sq_rem  <= '0;
      sq_root <= '0;
    end else if (cmd.sqrt_step) begin
      sq_n    <= sq_n_next;
      sq_rem  <= sq_rem_next;
      sq_root <= sq_root_next;
    end
  end

  // restoring dividers by the magnitude, two quotient bits per cycle
  always_comb begin
    logic [FW:0] rx_sh, ry_sh;
    dx_r_next = dx_r;
    dx_d_next = dx_d;
    qx_next   = qx;
    dy_r_next = dy_r;
    dy_d_next = dy_d;
    qy_next   = qy;
    for (int i = 0; i < kisl_pkg::STEPS_PER_CYCLE; i++) begin
      rx_sh     = {dx_r_next, dx_d_next[FW-1]};
      dx_d_next = {dx_d_next[FW-2:0], 1'b0};
      if (rx_sh >= {1'b0, sq_root}) begin
        rx_sh   = rx_sh - {1'b0, sq_root};
        qx_next = {qx_next[FW-2:0], 1'b1};
      end else begin
        qx_next = {qx_next[FW-2:0], 1'b0};
      end
      dx_r_next = rx_sh[FW-1:0];

      ry_sh     = {dy_r_next, dy_d_next[FW-1]};
      dy_d_next = {dy_d_next[FW-2:0], 1'b0};
      if (ry_sh >= {1'b0, sq_root}) begin
        ry_sh   = ry_sh - {1'b0, sq_root};
        qy_next = {qy_next[FW-2:0], 1'b1};
      end else begin
        qy_next = {qy_next[FW-2:0], 1'b0};
      end
      dy_r_next = ry_sh[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dx_r <= prod_x[PW-1:FW];
      dx_d <= prod_x[FW-1:0];
      qx   <= '0;
      dy_r <= prod[PW-1:FW];
      dy_d <= prod[FW-1:0];
      qy   <= '0;
    end else if (cmd.div_step) begin
      dx_r <= dx_r_next;
      dx_d <= dx_d_next;
      qx   <= qx_next;
      dy_r <= dy_r_next;
      dy_d <= dy_d_next;
      qy   <= qy_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.pos_x         <= position_x;
      out_data.pos_y         <= position_y;
      out_data.vel_x         <= velocity_x;
      out_data.vel_y         <= velocity_y;
      out_data.speed_limited <= limited;
    end
  end

endmodule

### design/kinematic_integrator_speed_limit.sv
// ---------------------------------------------------------------------------
// kinematic_integrator_speed_limit
// one agent's position, velocity and force sum in Q12.12 with a speed limit
// ---------------------------------------------------------------------------
// usage
//   in_valid/in_ready carry one command item; out_valid/out_ready carry one
//   result item per apply, tick or load. command 3 is taken and dropped.
//   cfg_wr_en/cfg_wr_data write max_speed at once; write only while idle.
// sequence, accept to out_valid
//   apply, load:            update, then hand-off to the output register
//   tick, within the limit:  velocity, magnitudes, squares, compare, position
//   tick, speed limited:    as above, with root, products, divide and scale
//   a new item is taken only in idle, which follows the hand-off of the
//   result to the output register. the limited case is set by the square
//   root and the divide, both two bits per cycle, plus the shared 24x24
//   multiplier, used for every square and product.
// reset
//   rst clears all agent state, restores max_speed to 4.0 and drops out_valid
// stall
//   a result waits in the output register while out_ready is low; the next
//   item is still taken and worked, and its result waits until the register
//   frees.
// ---------------------------------------------------------------------------
module kinematic_integrator_speed_limit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  kisl_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output kisl_pkg::out_item_t          out_data,
  input  logic                         cfg_wr_en,
  input  logic [kisl_pkg::SPEED_W-1:0] cfg_wr_data
);

  kisl_pkg::dp_cmd_t cmd;
  kisl_pkg::dp_sts_t sts;

  // sequencer
  kisl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // arithmetic and state
  kisl_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_data     (in_data),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

### design/kisl_checker.sv
// ---------------------------------------------------------------------------
// kisl_checker
// port-level checks of the kinematic integrator, bound to the top level
// ---------------------------------------------------------------------------
`include "kinematic_integrator_speed_limit_macros.svh"

module kisl_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input kisl_pkg::in_item_t           in_data,
  input logic                         out_valid,
  input logic                         out_ready,
  input kisl_pkg::out_item_t          out_data,
  input logic                         cfg_wr_en,
  input logic [kisl_pkg::SPEED_W-1:0] cfg_wr_data
);

  logic [1:0] pending;
  logic [kisl_pkg::SPEED_W-1:0] lim;
  logic [kisl_pkg::FIELD_W:0] abs_vx, abs_vy;
  logic in_take, out_take;
  logic vel_capped, pos_in_world;

  assign in_take  = in_valid && in_ready && (in_data.command != kisl_pkg::CMD_UNUSED);
  assign out_take = out_valid && out_ready;

  // items taken that still owe a result
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_take && !out_take) begin
      pending <= pending + 1'b1;
    end else if (out_take && !in_take) begin
      pending <= pending - 1'b1;
    end
  end

  // shadow of the speed limit
  always_ff @(posedge clk) begin
    if (rst) begin
      lim <= kisl_pkg::MAX_SPEED_RESET;
    end else if (cfg_wr_en) begin
      lim <= cfg_wr_data;
    end
  end

  // output velocity magnitudes
  assign abs_vx = out_data.vel_x[kisl_pkg::FIELD_W-1] ?
                  ((kisl_pkg::FIELD_W+1)'(0) - {1'b1, out_data.vel_x}) :
                  {1'b0, out_data.vel_x};
  assign abs_vy = out_data.vel_y[kisl_pkg::FIELD_W-1] ?
                  ((kisl_pkg::FIELD_W+1)'(0) - {1'b1, out_data.vel_y}) :
                  {1'b0, out_data.vel_y};

  // velocity within the cap, position inside the world
  assign vel_capped   = (abs_vx <= {2'b00, lim}) && (abs_vy <= {2'b00, lim});
  assign pos_in_world = (out_data.pos_x >= 0) && (out_data.pos_x <= kisl_pkg::WRAP_X) &&
                        (out_data.pos_y >= 0) && (out_data.pos_y <= kisl_pkg::WRAP_Y);

  `KISL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `KISL_ASSERT_IMPL(a_no_spurious, out_valid, pending != 2'd0)
  `KISL_ASSERT_IMPL(a_pending_bound, 1'b1, pending != 2'd3)
  `KISL_ASSERT_IMPL(a_limit_bound, out_valid && out_data.speed_limited, vel_capped)
  `KISL_ASSERT_IMPL(a_wrapped, out_valid && out_data.speed_limited, pos_in_world)

endmodule

bind kinematic_integrator_speed_limit kisl_checker u_kisl_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_data     (in_data),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_data    (out_data),
  .cfg_wr_en   (cfg_wr_en),
  .cfg_wr_data (cfg_wr_data)
);

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// checks the kinematic integrator against a cycle-free copy of its behavior:
// commands go in through a queue-fed driver, every result is compared field
// by field with the oldest prediction, under varying speed caps and idling
// ---------------------------------------------------------------------------
module tb;

  localparam int FW = kisl_pkg::FIELD_W;
  localparam int SW = kisl_pkg::SPEED_W;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  kisl_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  kisl_pkg::out_item_t out_data;
  logic                cfg_wr_en = 1'b0;
  logic [SW-1:0]       cfg_wr_data = '0;

  // predicted agent state and speed cap
  logic signed [FW-1:0] agent_px, agent_py, agent_vx, agent_vy;
  logic signed [FW-1:0] agent_fx, agent_fy;
  logic [SW-1:0]        speed_cap;

  kisl_pkg::in_item_t  pending_cmds[$];
  kisl_pkg::out_item_t expected_states[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int error_count = 0;
  bit stall_req = 1'b0;
  bit stall_served = 1'b0;
  int stall_left = 0;

  kinematic_integrator_speed_limit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic log_mismatch(input string what);
    error_count++;
    $display("mismatch: %s", what);
  endtask

  // saturating add at the field range
  function automatic logic signed [FW-1:0] sat_field(
    input logic signed [FW-1:0] a,
    input logic signed [FW-1:0] b
  );
    longint s;
    s = longint'(a) + longint'(b);
    if (s > kisl_pkg::FIELD_MAX_INT) begin
      return kisl_pkg::FIELD_MAX;
    end
    if (s < -longint'(kisl_pkg::FIELD_MAX_INT) - 1) begin
      return kisl_pkg::FIELD_MIN;
    end
    return FW'(s);
  endfunction

  function automatic logic signed [FW-1:0] wrap_to_world(
    input logic signed [FW-1:0] p,
    input logic signed [FW-1:0] lim
  );
    if (p > lim) begin
      return '0;
    end
    if (p < 0) begin
      return lim;
    end
    return p;
  endfunction

  // floor square root, one result bit per trial
  function automatic longint unsigned isqrt_floor(input longint unsigned n);
    longint unsigned root, trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // sign(v) * floor(|v| * cap / mag)
  function automatic logic signed [FW-1:0] scale_to_cap(
    input longint v,
    input longint unsigned cap,
    input longint unsigned mag
  );
    longint unsigned a, q;
    a = (v < 0) ? -v : v;
    q = (a * cap) / mag;
    return (v < 0) ? FW'(-longint'(q)) : FW'(q);
  endfunction

  // one accepted command: update the agent, queue the result it produces
  function automatic void advance_agent(input kisl_pkg::in_item_t cmd);
    kisl_pkg::out_item_t res;
    longint vx, vy;
    longint unsigned m2, cap, mag;
    res = '0;
    case (cmd.command)
      kisl_pkg::CMD_APPLY: begin
        agent_fx = sat_field(agent_fx, cmd.vec_x);
        agent_fy = sat_field(agent_fy, cmd.vec_y);
      end
      kisl_pkg::CMD_TICK: begin
        agent_vx = sat_field(agent_vx, agent_fx);
        agent_vy = sat_field(agent_vy, agent_fy);
        vx = agent_vx;
        vy = agent_vy;
        m2 = vx * vx + vy * vy;
        cap = speed_cap;
        if (m2 > cap * cap) begin
          mag = isqrt_floor(m2);
          if (mag == 0) begin
            mag = 1;
          end
          agent_vx = scale_to_cap(vx, cap, mag);
          agent_vy = scale_to_cap(vy, cap, mag);
          res.speed_limited = 1'b1;
        end
        agent_px = wrap_to_world(sat_field(agent_px, agent_vx), kisl_pkg::WRAP_X);
        agent_py = wrap_to_world(sat_field(agent_py, agent_vy), kisl_pkg::WRAP_Y);
        agent_fx = '0;
        agent_fy = '0;
      end
      kisl_pkg::CMD_LOAD: begin
        agent_px = cmd.vec_x;
        agent_py = cmd.vec_y;
        agent_vx = cmd.load_vel_x;
        agent_vy = cmd.load_vel_y;
        agent_fx = '0;
        agent_fy = '0;
      end
      default: begin
        return;
      end
    endcase
    res.pos_x = agent_px;
    res.pos_y = agent_py;
    res.vel_x = agent_vx;
    res.vel_y = agent_vy;
    expected_states.push_back(res);
  endfunction

  task automatic cmp_field(input string name, input longint got, input longint want);
    if (got != want) begin
      log_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  // driver: holds valid and payload until taken
  always @(posedge clk) begin : drive_cmds
    logic next_valid;
    next_valid = in_valid;
    if (rst) begin
      next_valid = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        advance_agent(in_data);
        next_valid = 1'b0;
      end
      if (!next_valid && pending_cmds.size() != 0 &&
          $urandom_range(99) >= tx_idle_pct) begin
        in_data <= pending_cmds.pop_front();
        next_valid = 1'b1;
      end
    end
    in_valid <= next_valid;
  end

  // monitor: checks results and drives the receiver stall
  always @(posedge clk) begin : watch_results
    kisl_pkg::out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_states.size() == 0) begin
          log_mismatch("result with nothing expected");
        end else begin
          want = expected_states.pop_front();
          cmp_field("pos_x", out_data.pos_x, want.pos_x);
          cmp_field("pos_y", out_data.pos_y, want.pos_y);
          cmp_field("vel_x", out_data.vel_x, want.vel_x);
          cmp_field("vel_y", out_data.vel_y, want.vel_y);
          cmp_field("speed_limited", out_data.speed_limited, want.speed_limited);
        end
      end
      if (stall_req && !stall_served) begin
        stall_served = 1'b1;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic kisl_pkg::in_item_t make_cmd(input logic [1:0] c, input int x,
                                                  input int y, input int vx, input int vy);
    kisl_pkg::in_item_t it;
    it.command    = c;
    it.vec_x      = FW'(x);
    it.vec_y      = FW'(y);
    it.load_vel_x = FW'(vx);
    it.load_vel_y = FW'(vy);
    return it;
  endfunction

  // random fixed-point value, magnitude set by a random shift
  function automatic logic signed [FW-1:0] rand_fixed();
    logic signed [FW-1:0] v;
    int shifts[6] = '{0, 6, 9, 11, 13, 16};
    v = FW'($urandom);
    return v >>> shifts[$urandom_range(5)];
  endfunction

  // position near or inside the world, sometimes anywhere
  function automatic logic signed [FW-1:0] rand_position();
    int pick;
    pick = $urandom_range(9);
    if (pick < 6) begin
      return FW'($urandom_range(0, kisl_pkg::WRAP_X_INT));
    end
    if (pick == 6) begin
      return FW'(kisl_pkg::WRAP_X_INT - $urandom_range(0, 64));
    end
    if (pick == 7) begin
      return FW'($urandom_range(0, 64));
    end
    return FW'($urandom);
  endfunction

  task automatic queue_random(input int count);
    kisl_pkg::in_item_t it;
    int pick;
    for (int i = 0; i < count; i++) begin
      it = make_cmd(kisl_pkg::CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
      pick = $urandom_range(99);
      if (pick < 10) begin
        it.command    = kisl_pkg::CMD_LOAD;
        it.vec_x      = rand_position();
        it.vec_y      = rand_position();
        it.load_vel_x = rand_fixed();
        it.load_vel_y = rand_fixed();
      end else if (pick < 45) begin
        it.command = kisl_pkg::CMD_APPLY;
        it.vec_x   = rand_fixed();
        it.vec_y   = rand_fixed();
      end else if (pick < 90) begin
        it.command = kisl_pkg::CMD_TICK;
      end else if (pick >= 95) begin
        it.command = 2'($urandom);
      end
      pending_cmds.push_back(it);
    end
  endtask

  // sender pause until everything sent has come back, then let the block settle
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (pending_cmds.size() != 0 || in_valid || expected_states.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_speed_cap(input logic [SW-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    speed_cap = v;
  endtask

  task automatic set_idle(input int tx, input int rx);
    @(negedge clk);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
  endtask

  // stimulus
  initial begin : run_phases
    int drain;
    agent_px = '0;
    agent_py = '0;
    agent_vx = '0;
    agent_vy = '0;
    agent_fx = '0;
    agent_fy = '0;
    speed_cap = kisl_pkg::MAX_SPEED_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed, at the reset speed cap of 4.0
    set_idle(34, 72);
    @(negedge clk);
    pending_cmds.push_back(make_cmd(kisl_pkg::CMD_TICK, 0, 0, 0, 0));
    // accumulator saturates both ways
    pending_cmds.push_back(make_cmd(kisl_pkg::CMD_APPLY, kisl_pkg::FIELD_MAX_INT,
                                    -8388608, 0, 0));
    pending_cmds.push_back(make_cmd(kisl_pkg::CMD_APPLY, kisl_pkg::FIELD_MAX_INT,
                                    -8388608, 0, 0));
    pending_cmds.push_back(make_cmd(kisl_pkg::CMD_TICK, 0, 0, 0, 0));
    // extreme load, then a limited tick with both position wraps
    pending_cmds.push_back(make_cmd(kisl_pkg::CMD_LOAD, kisl_pkg::FIELD_MAX_INT, -8388608,
                                    -8388608, kisl_pkg::FIELD_MAX_INT));
    pending_cmds.push_back(make_cmd(kisl_pkg::CMD_TICK, 0, 0, 0, 0));
    // unused command is dropped
    pending_cmds.push_back(make_cmd(kisl_pkg::CMD_UNUSED, -1, -1, -1, -1));
    // step just past the x limit and just below zero on y
    pending_cmds.push_back(make_cmd(kisl_pkg::CMD_LOAD, kisl_pkg::WRAP_X_INT, 0, 1, -1));
    pending_cmds.push_back(make_cmd(kisl_pkg::CMD_TICK, 0, 0, 0, 0));
    // sitting exactly on the limit and on zero does not wrap
    pending_cmds.push_back(make_cmd(kisl_pkg::CMD_LOAD, kisl_pkg::WRAP_X_INT, 0, 0, 0));
    pending_cmds.push_back(make_cmd(kisl_pkg::CMD_TICK, 0, 0, 0, 0));
    // speed exactly at the cap is left alone, one above is scaled
    pending_cmds.push_back(make_cmd(kisl_pkg::CMD_LOAD, 100, 200, 16384, 0));
    pending_cmds.push_back(make_cmd(kisl_pkg::CMD_TICK, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(kisl_pkg::CMD_LOAD, 100, 200, 16385, 0));
    pending_cmds.push_back(make_cmd(kisl_pkg::CMD_TICK, 0, 0, 0, 0));
    // load clears a pending force
    pending_cmds.push_back(make_cmd(kisl_pkg::CMD_APPLY, 5000, -5000, 0, 0));
    pending_cmds.push_back(make_cmd(kisl_pkg::CMD_LOAD, 4096, 4096, -3, 4));
    pending_cmds.push_back(make_cmd(kisl_pkg::CMD_TICK, 0, 0, 0, 0));
    // opposite forces cancel
    pending_cmds.push_back(make_cmd(kisl_pkg::CMD_APPLY, -1, -1, 0, 0));
    pending_cmds.push_back(make_cmd(kisl_pkg::CMD_APPLY, 1, 1, 0, 0));
    pending_cmds.push_back(make_cmd(kisl_pkg::CMD_TICK, 0, 0, 0, 0));
    // most negative velocity scaled down
    pending_cmds.push_back(make_cmd(kisl_pkg::CMD_LOAD, 8192, 8192, -8388608, 0));
    pending_cmds.push_back(make_cmd(kisl_pkg::CMD_TICK, 0, 0, 0, 0));
    wait_idle();

    // random, default cap written explicitly
    set_speed_cap(kisl_pkg::MAX_SPEED_RESET);
    queue_random(100);
    wait_idle();
    queue_random(100);
    wait_idle();

    // zero cap: any motion is stopped
    set_idle(72, 34);
    set_speed_cap('0);
    queue_random(60);
    wait_idle();

    set_speed_cap(SW'($urandom_range(1, 65535)));
    queue_random(150);
    wait_idle();

    // largest cap
    set_idle(0, 0);
    set_speed_cap({SW{1'b1}});
    queue_random(70);
    wait_idle();

    // long receiver hold-off while the sender keeps offering
    set_speed_cap(SW'($urandom_range(0, 8388607)));
    @(negedge clk);
    stall_req = 1'b1;
    queue_random(100);
    wait_idle();

    drain = 0;
    while (expected_states.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (40) @(posedge clk);
    if (expected_states.size() != 0) begin
      log_mismatch($sformatf("%0d results never arrived", expected_states.size()));
    end
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // overall time limit
  initial begin : watchdog
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
